>>> hw/rtl/gif_sub_block_framer_unit_defines.svh
// Assertion macros used by the checker of the sub-block framer.
`ifndef GIF_SUB_BLOCK_FRAMER_UNIT_DEFINES_SVH
`define GIF_SUB_BLOCK_FRAMER_UNIT_DEFINES_SVH

// Checked at every edge, reset included.
`define GSBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only.
`define GSBF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> hw/rtl/gsbf_pkg.sv
package gsbf_pkg;

   parameter int MAX_BLOCK_BYTES = 255;
   parameter int BLOCK_CAP_BITS  = MAX_BLOCK_BYTES * 8;
   parameter int CAP_W           = $clog2(BLOCK_CAP_BITS + 8);

   parameter int FIFO_DEPTH = 4;
   parameter int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   parameter int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   parameter logic [7:0] CODE_SIZE_RESET = 8'd8;

   parameter logic CSR_CODE_SIZE  = 1'b0;
   parameter logic CSR_TOTAL_BITS = 1'b1;

   parameter logic [1:0] ROLE_CODE_SIZE  = 2'd0;
   parameter logic [1:0] ROLE_BLOCK_LEN  = 2'd1;
   parameter logic [1:0] ROLE_DATA       = 2'd2;
   parameter logic [1:0] ROLE_TERMINATOR = 2'd3;

   parameter logic KIND_START = 1'b0;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] role;
   } result_type;

   // One queue entry holds every beat that a single item produces.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   function automatic logic [7:0] block_length(input logic [31:0] rem);
      logic [CAP_W-1:0] rounded;
      rounded = CAP_W'(rem) + CAP_W'(7);
      if (rem > 32'(BLOCK_CAP_BITS)) begin
         return 8'(MAX_BLOCK_BYTES);
      end
      return 8'(rounded >> 3);
   endfunction

endpackage

>>> hw/rtl/gif_sub_block_framer_unit.sv
// GIF data sub-block framer.
// Input channel (req_push / req_full): one beat is either a frame start
// (req_kind low) or one compressed bit (req_kind high, bit on req_data_bit).
// Result channel (rsp_empty / rsp_pop): one beat per stream byte with its role
// (code size, block length, data, terminator); rsp_last marks the final beat
// that an input beat caused.
// Configuration (csr_we / csr_index / csr_wdata): code size at index 0 and the
// frame's bit count at index 1, which the user writes only while the block is
// idle; the block itself does not enforce this.
// Latency: a result is on the result ports from the edge after the one that
// accepts the beat that caused it, when the result side is drained. Throughput:
// one input beat per cycle while req_full is low; a beat with two results holds
// the back part for both, so a long run of them fills the four-entry queue
// between the front and back parts, then enters as the back part drains.
// Data bits that do not complete a byte cause no result, but like every beat
// they wait while req_full is high. Reset clears the frame state, empties the
// queue and restores code size 8 and a bit count of zero. When the receiver
// stops popping, the queue fills and req_full rises; nothing is dropped.
module gif_sub_block_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic        req_data_bit,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_byte_role,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import gsbf_pkg::*;

   entry_type push_data, head;
   logic      push, pop, q_full, q_empty;

   gsbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_kind     (req_kind),
      .req_data_bit (req_data_bit),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (push),
      .q_data       (push_data)
   );

   gsbf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   gsbf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (head),
      .q_empty       (q_empty),
      .q_pop         (pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_byte_role (rsp_byte_role),
      .rsp_last      (rsp_last)
   );

   assign req_full = q_full;

endmodule

>>> hw/rtl/gsbf_front.sv
module gsbf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic                req_kind,
   input  logic                req_data_bit,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                q_full,
   output logic                q_push,
   output gsbf_pkg::entry_type q_data
);
   import gsbf_pkg::*;

   logic [7:0]  code_size_ff;
   logic [31:0] total_bits_ff;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  bib_ff, bib_in;
   logic        in_frame_ff, in_frame_in;

   logic        accept;
   logic [7:0]  acc_new;
   logic [7:0]  bib_dec;
   logic [31:0] rem_dec;
   logic        final_bit;

   assign accept    = req_push & ~q_full;
   assign acc_new   = acc_ff | (8'(req_data_bit) << pos_ff);
   assign bib_dec   = bib_ff - 8'd1;
   assign rem_dec   = rem_ff - 32'd1;
   assign final_bit = (rem_ff == 32'd1);

   always_comb begin
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      bib_in      = bib_ff;
      in_frame_in = in_frame_ff;
      q_push      = 1'b0;
      q_data      = '0;
      if (accept) begin
         if (req_kind == KIND_START) begin
            q_push       = 1'b1;
            q_data.two   = 1'b1;
            q_data.first = '{value: code_size_ff, role: ROLE_CODE_SIZE};
            acc_in       = '0;
            pos_in       = '0;
            rem_in       = total_bits_ff;
            if (total_bits_ff == 32'd0) begin
               q_data.second = '{value: 8'd0, role: ROLE_TERMINATOR};
               bib_in        = '0;
               in_frame_in   = 1'b0;
            end else begin
               bib_in        = block_length(total_bits_ff);
               q_data.second = '{value: block_length(total_bits_ff), role: ROLE_BLOCK_LEN};
               in_frame_in   = 1'b1;
            end
         end else if (in_frame_ff) begin
            rem_in = rem_dec;
            if (pos_ff == 3'd7 || final_bit) begin
               q_push       = 1'b1;
               q_data.first = '{value: acc_new, role: ROLE_DATA};
               acc_in       = '0;
               pos_in       = '0;
               if (final_bit) begin
                  q_data.two    = 1'b1;
                  q_data.second = '{value: 8'd0, role: ROLE_TERMINATOR};
                  bib_in        = '0;
                  in_frame_in   = 1'b0;
               end else if (bib_dec == 8'd0) begin
                  // The block is full, so a new length beat opens the next one.
                  q_data.two    = 1'b1;
                  bib_in        = block_length(rem_dec);
                  q_data.second = '{value: block_length(rem_dec), role: ROLE_BLOCK_LEN};
               end else begin
                  bib_in = bib_dec;
               end
            end else begin
               acc_in = acc_new;
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_size_ff  <= CODE_SIZE_RESET;
         total_bits_ff <= '0;
         rem_ff        <= '0;
         acc_ff        <= '0;
         pos_ff        <= '0;
         bib_ff        <= '0;
         in_frame_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CODE_SIZE:  code_size_ff  <= csr_wdata[7:0];
               CSR_TOTAL_BITS: total_bits_ff <= csr_wdata;
               default: ;
            endcase
         end
         rem_ff      <= rem_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
         bib_ff      <= bib_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

>>> hw/rtl/gsbf_fifo.sv
module gsbf_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gsbf_pkg::entry_type push_data,
   input  logic                pop,
   output gsbf_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import gsbf_pkg::*;

   entry_type             slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? FIFO_PTR_W'((32'(wr_ff) + 1) % FIFO_DEPTH) : wr_ff;
      rd_in  = do_pop  ? FIFO_PTR_W'((32'(rd_ff) + 1) % FIFO_DEPTH) : rd_ff;
      cnt_in = cnt_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/gsbf_back.sv
module gsbf_back (
   input  logic                clock,
   input  logic                reset,
   input  gsbf_pkg::entry_type q_head,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_byte_role,
   output logic                rsp_last
);
   import gsbf_pkg::*;

   entry_type  cur_ff, cur_in;
   logic       sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic       take, to_second, need_load;
   result_type shown;

   assign take      = rsp_pop & valid_ff;
   assign to_second = take & cur_ff.two & ~sel_ff;
   assign need_load = ~valid_ff | (take & ~to_second);
   assign q_pop     = need_load & ~q_empty;

   always_comb begin
      cur_in   = cur_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (to_second) begin
         sel_in = 1'b1;
      end else if (need_load) begin
         cur_in   = q_head;
         sel_in   = 1'b0;
         valid_in = ~q_empty;
      end
   end

   assign shown         = sel_ff ? cur_ff.second : cur_ff.first;
   assign rsp_empty     = ~valid_ff;
   assign rsp_out_byte  = shown.value;
   assign rsp_byte_role = shown.role;
   assign rsp_last      = sel_ff | ~cur_ff.two;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> hw/rtl/gsbf_checker.sv
`include "gif_sub_block_framer_unit_defines.svh"

module gsbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_byte_role,
   input logic        rsp_last
);
   import gsbf_pkg::*;

   // A waiting beat that is not popped stays on the ports unchanged.
   `GSBF_ASSERT(a_rsp_hold, clock, reset,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte) &&
      $stable(rsp_byte_role) && $stable(rsp_last)),
      "result beat changed while stalled")

   // A terminator is a zero byte and always ends its item's results.
   `GSBF_ASSERT(a_term_form, clock, reset,
      (!rsp_empty && rsp_byte_role == ROLE_TERMINATOR) |-> (rsp_last && rsp_out_byte == 8'd0),
      "malformed terminator beat")

   // A block length is never zero, ends its item, and a code size never does.
   `GSBF_ASSERT(a_len_form, clock, reset,
      (!rsp_empty && rsp_byte_role == ROLE_BLOCK_LEN) |-> (rsp_last && rsp_out_byte != 8'd0),
      "malformed block length beat")
   `GSBF_ASSERT(a_cs_not_last, clock, reset,
      (!rsp_empty && rsp_byte_role == ROLE_CODE_SIZE) |-> !rsp_last,
      "code size beat marked last")

   // Reset leaves both channels idle.
   `GSBF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (rsp_empty && !req_full),
      "channels not idle after reset")

endmodule

bind gif_sub_block_framer_unit gsbf_checker u_gsbf_checker (.*);

>>> tb/tb_gif_sub_block_framer_unit.sv
module tb_gif_sub_block_framer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import gsbf_pkg::*;

   localparam logic KIND_DATA   = ~KIND_START;
   localparam int   QUIET_LIMIT = 2000;
   localparam int   SMALL_ITEMS = 625;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] role;
      logic       last;
   } stream_beat_type;

   typedef struct packed {
      logic        is_write;
      logic        reg_sel;
      logic [31:0] wval;
      logic        kind;
      logic        bitv;
      logic        typed;
      logic [1:0]  n_typed;
      logic [7:0]  v0;
      logic [1:0]  r0;
      logic [7:0]  v1;
      logic [1:0]  r1;
   } script_row_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_push     = 1'b0;
   logic        req_full;
   logic        req_kind     = KIND_START;
   logic        req_data_bit = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop      = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_byte_role;
   logic        rsp_last;
   logic        csr_we       = 1'b0;
   logic        csr_index    = CSR_CODE_SIZE;
   logic [31:0] csr_wdata    = '0;

   gif_sub_block_framer_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_data_bit  (req_data_bit),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_byte_role (rsp_byte_role),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Shadow of the framer: configuration and frame state.
   logic [7:0]  code_size_q  = CODE_SIZE_RESET;
   logic [31:0] frame_bits_q = '0;
   logic [31:0] bits_left    = '0;
   logic [7:0]  partial_byte = '0;
   logic [2:0]  bit_slot     = '0;
   logic [7:0]  block_left   = '0;
   logic        frame_open   = 1'b0;

   stream_beat_type due_beats[$];
   stream_beat_type fresh_beats[$];
   int              mismatches   = 0;
   int              items_sent   = 0;
   int              quiet_cycles = 0;
   bit              steady       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_mismatch(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void append_due(input stream_beat_type beat);
      due_beats.insert(due_beats.size(), beat);
   endfunction

   function automatic logic [7:0] bytes_for(input logic [31:0] left);
      logic [31:0] capped;
      capped = (left > 32'(MAX_BLOCK_BYTES * 8)) ? 32'(MAX_BLOCK_BYTES * 8) : left;
      return 8'((capped + 32'd7) >> 3);
   endfunction

   function automatic void emit(input logic [7:0] value, input logic [1:0] role);
      fresh_beats.insert(fresh_beats.size(), stream_beat_type'{value, role, 1'b0});
   endfunction

   // Works out the stream bytes that one input beat produces into fresh_beats.
   function automatic void framer_step(input logic kind, input logic bitv);
      fresh_beats.delete();
      if (kind == KIND_START) begin
         emit(code_size_q, ROLE_CODE_SIZE);
         partial_byte = '0;
         bit_slot     = '0;
         bits_left    = frame_bits_q;
         if (bits_left == 0) begin
            emit(8'd0, ROLE_TERMINATOR);
            block_left = '0;
            frame_open = 1'b0;
         end else begin
            block_left = bytes_for(bits_left);
            emit(block_left, ROLE_BLOCK_LEN);
            frame_open = 1'b1;
         end
      end else if (frame_open) begin
         // Bits land least significant first; higher bits are still clear.
         partial_byte[bit_slot] = bitv;
         bits_left = bits_left - 1;
         if (bit_slot == 3'd7 || bits_left == 0) begin
            emit(partial_byte, ROLE_DATA);
            partial_byte = '0;
            bit_slot     = '0;
            block_left   = block_left - 8'd1;
            if (bits_left == 0) begin
               emit(8'd0, ROLE_TERMINATOR);
               block_left = '0;
               frame_open = 1'b0;
            end else if (block_left == 0) begin
               block_left = bytes_for(bits_left);
               emit(block_left, ROLE_BLOCK_LEN);
            end
         end else begin
            bit_slot = bit_slot + 3'd1;
         end
      end
      if (fresh_beats.size() > 0) begin
         fresh_beats[fresh_beats.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic script_row_type csr_row(input logic sel, input logic [31:0] value);
      script_row_type r;
      r          = '0;
      r.is_write = 1'b1;
      r.reg_sel  = sel;
      r.wval     = value;
      return r;
   endfunction

   function automatic script_row_type beat_row(input logic kind, input logic bitv);
      script_row_type r;
      r      = '0;
      r.kind = kind;
      r.bitv = bitv;
      return r;
   endfunction

   function automatic script_row_type known_row(input logic kind, input logic bitv,
                                                input logic [1:0] n,
                                                input logic [7:0] v0, input logic [1:0] r0,
                                                input logic [7:0] v1, input logic [1:0] r1);
      script_row_type r;
      r         = beat_row(kind, bitv);
      r.typed   = 1'b1;
      r.n_typed = n;
      r.v0      = v0;
      r.r0      = r0;
      r.v1      = v1;
      r.r1      = r1;
      return r;
   endfunction

   // Offers one beat, idling at random beforehand, and returns at the edge that takes it.
   task automatic send_beat(input logic kind, input logic bitv);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_kind     <= kind;
      req_data_bit <= bitv;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (items_sent == 150) begin
         steady = 1'b1;
      end else if (items_sent == 450) begin
         steady = 1'b0;
      end
   endtask

   task automatic feed(input logic kind, input logic bitv);
      send_beat(kind, bitv);
      framer_step(kind, bitv);
      foreach (fresh_beats[i]) append_due(fresh_beats[i]);
   endtask

   // Registers change only once every due byte is out and the pipeline has settled.
   task automatic write_reg(input logic sel, input logic [31:0] value);
      req_push <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_CODE_SIZE) begin
         code_size_q = value[7:0];
      end else begin
         frame_bits_q = value;
      end
   endtask

   always @(posedge clock) begin : drain_results
      stream_beat_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_beats.size() == 0) begin
               note_mismatch($sformatf("unexpected beat byte %h role %0d last %b",
                                       rsp_out_byte, rsp_byte_role, rsp_last));
            end else begin
               want = due_beats.pop_front();
               if (rsp_out_byte !== want.value) begin
                  note_mismatch($sformatf("out_byte %h, wanted %h", rsp_out_byte, want.value));
               end
               if (rsp_byte_role !== want.role) begin
                  note_mismatch($sformatf("byte_role %0d, wanted %0d",
                                          rsp_byte_role, want.role));
               end
               if (rsp_last !== want.last) begin
                  note_mismatch($sformatf("last %b, wanted %b", rsp_last, want.last));
               end
            end
         end
         rsp_pop <= steady || ($urandom_range(0, 99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type script[$];
      script_row_type row;
      logic [31:0]    total;
      logic [7:0]     code;
      int             frame_len;
      int             pre_bits;

      script = '{
         // A bit with no frame open is dropped.
         known_row(KIND_DATA, 1'b1, 2'd0, 8'd0, ROLE_DATA, 8'd0, ROLE_DATA),
         known_row(KIND_START, 1'b0, 2'd2, CODE_SIZE_RESET, ROLE_CODE_SIZE,
                   8'd0, ROLE_TERMINATOR),
         known_row(KIND_DATA, 1'b0, 2'd0, 8'd0, ROLE_DATA, 8'd0, ROLE_DATA),
         csr_row(CSR_CODE_SIZE, 32'd255),
         csr_row(CSR_TOTAL_BITS, 32'd1),
         known_row(KIND_START, 1'b1, 2'd2, 8'd255, ROLE_CODE_SIZE, 8'd1, ROLE_BLOCK_LEN),
         known_row(KIND_DATA, 1'b1, 2'd2, 8'd1, ROLE_DATA, 8'd0, ROLE_TERMINATOR),
         csr_row(CSR_CODE_SIZE, 32'd0),
         csr_row(CSR_TOTAL_BITS, 32'hFFFF_FFFF),
         known_row(KIND_START, 1'b0, 2'd2, 8'd0, ROLE_CODE_SIZE, 8'd255, ROLE_BLOCK_LEN),
         beat_row(KIND_DATA, 1'b1), beat_row(KIND_DATA, 1'b1),
         beat_row(KIND_DATA, 1'b1), beat_row(KIND_DATA, 1'b1),
         beat_row(KIND_DATA, 1'b1), beat_row(KIND_DATA, 1'b1),
         beat_row(KIND_DATA, 1'b1), beat_row(KIND_DATA, 1'b1),
         // Restarting abandons the open frame without a terminator.
         csr_row(CSR_TOTAL_BITS, 32'd2040),
         known_row(KIND_START, 1'b1, 2'd2, 8'd0, ROLE_CODE_SIZE, 8'd255, ROLE_BLOCK_LEN),
         beat_row(KIND_DATA, 1'b0), beat_row(KIND_DATA, 1'b1),
         // A new bit count written mid-frame waits for the next start.
         csr_row(CSR_TOTAL_BITS, 32'd3),
         beat_row(KIND_DATA, 1'b1),
         beat_row(KIND_START, 1'b0),
         beat_row(KIND_DATA, 1'b1), beat_row(KIND_DATA, 1'b0), beat_row(KIND_DATA, 1'b1),
         beat_row(KIND_DATA, 1'b1)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) begin
            write_reg(row.reg_sel, row.wval);
         end else if (!row.typed) begin
            feed(row.kind, row.bitv);
         end else begin
            send_beat(row.kind, row.bitv);
            framer_step(row.kind, row.bitv);
            if (row.n_typed != 0) begin
               append_due(stream_beat_type'{row.v0, row.r0, row.n_typed == 2'd1});
            end
            if (row.n_typed == 2'd2) begin
               append_due(stream_beat_type'{row.v1, row.r1, 1'b1});
            end
         end
      end

      // Mostly whole frames of random bits, with stray, short and overlong ones mixed in.
      while (items_sent < SMALL_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       code = 8'd0;
            1:       code = 8'd255;
            default: code = 8'($urandom_range(0, 255));
         endcase
         write_reg(CSR_CODE_SIZE, {24'd0, code});
         case ($urandom_range(0, 19))
            0, 1:    total = 32'd0;
            2:       total = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            3:       total = $urandom;
            4, 5:    total = 32'($urandom_range(41, 300));
            default: total = 32'($urandom_range(1, 40));
         endcase
         write_reg(CSR_TOTAL_BITS, total);
         pre_bits = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
         repeat (pre_bits) feed(KIND_DATA, 1'($urandom_range(0, 1)));
         feed(KIND_START, 1'($urandom_range(0, 1)));
         frame_len = (total > 32'd300) ? $urandom_range(0, 300) : int'(total);
         case ($urandom_range(0, 9))
            0:       frame_len = $urandom_range(0, frame_len);
            1:       frame_len = frame_len + $urandom_range(1, 4);
            default: ;
         endcase
         repeat (frame_len) feed(KIND_DATA, 1'($urandom_range(0, 1)));
      end

      req_push <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
